// ===== hdl/sdd_pkg.sv =====
// Package for the setup/delayed-off server dispatcher.
// Holds server mode codes, register codes, the cell command struct and shared helpers.
// No dependencies.
`default_nettype none
package sdd_pkg;

   localparam int TAG_W     = 16;
   localparam int CFG_W     = 16;
   localparam int INUSE_W   = 4;
   localparam int QJOBS_W   = 7;
   localparam int SIDX_W    = 3;
   localparam int PADDR_W   = 4;
   localparam int PDATA_W   = 32;

   typedef enum logic [1:0] {
      MODE_OFF   = 2'd0,
      MODE_SETUP = 2'd1,
      MODE_BUSY  = 2'd2,
      MODE_DOFF  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_SETUP_TICKS = 2'd0,
      REG_DOFF_TICKS  = 2'd1,
      REG_IN_USE      = 2'd2,
      REG_NONE        = 2'd3
   } reg_idx_type;

   localparam logic [1:0] RANK_DOFF = 2'd0;
   localparam logic [1:0] RANK_OFF  = 2'd1;
   localparam logic [1:0] RANK_SETUP = 2'd2;
   localparam logic [1:0] RANK_BUSY = 2'd3;

   // Command to one server cell for the current cycle.
   typedef struct packed {
      logic tick;
      logic start;
      logic power_up;
      logic shut_off;
   } cell_cmd_type;

   // Dispatch preference: lower is better.
   function automatic logic [1:0] rank_of(input mode_type m);
      logic [1:0] r;
      unique case (m)
         MODE_DOFF:  r = RANK_DOFF;
         MODE_OFF:   r = RANK_OFF;
         MODE_SETUP: r = RANK_SETUP;
         default:    r = RANK_BUSY;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/sdd_server_cell.sv =====
// One server of the dispatcher: power state and the setup, idle and service countdowns.
// Depends on sdd_pkg.
`default_nettype none
module sdd_server_cell
   import sdd_pkg::*;
#(
   parameter int TIME_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cell_cmd_type         cmd,
   input  wire logic [TIME_BITS-1:0] setup_ticks,
   input  wire logic [TIME_BITS-1:0] doff_ticks,
   input  wire logic [TIME_BITS-1:0] job_svc,
   input  wire logic [TAG_W-1:0]     job_tag,
   output mode_type                  mode,
   output logic [TIME_BITS-1:0]      idle_left,
   output logic                      dep,
   output logic [TAG_W-1:0]          dep_tag
);

   mode_type               mode_ff, mode_in;
   logic [TIME_BITS-1:0]   setup_ff, setup_in;
   logic [TIME_BITS-1:0]   idle_ff, idle_in;
   logic [TIME_BITS-1:0]   svc_ff, svc_in;
   logic [TAG_W-1:0]       tag_ff, tag_in;
   logic                   dep_ff, dep_in;
   logic [TAG_W-1:0]       dtag_ff, dtag_in;

   always_comb begin
      mode_in  = mode_ff;
      setup_in = setup_ff;
      idle_in  = idle_ff;
      svc_in   = svc_ff;
      tag_in   = tag_ff;
      dep_in   = dep_ff;
      dtag_in  = dtag_ff;
      if (cmd.tick) begin
         dep_in = 1'b0;
         // setup ends into delayed-off, which runs down in the same tick
         if (mode_in == MODE_SETUP) begin
            if (setup_in != '0) setup_in = setup_in - 1'b1;
            if (setup_in == '0) begin
               mode_in = MODE_DOFF;
               idle_in = doff_ticks;
            end
         end
         if (mode_in == MODE_DOFF) begin
            if (idle_in != '0) idle_in = idle_in - 1'b1;
            if (idle_in == '0) mode_in = MODE_OFF;
         end
         if (mode_in == MODE_BUSY) begin
            if (svc_in != '0) svc_in = svc_in - 1'b1;
            if (svc_in == '0) begin
               mode_in = MODE_DOFF;
               idle_in = doff_ticks;
               dep_in  = 1'b1;
               dtag_in = tag_ff;
            end
         end
      end else if (cmd.start) begin
         mode_in = MODE_BUSY;
         svc_in  = job_svc;
         tag_in  = job_tag;
      end else if (cmd.power_up) begin
         mode_in  = MODE_SETUP;
         setup_in = setup_ticks;
      end else if (cmd.shut_off && mode_ff == MODE_SETUP) begin
         mode_in = MODE_OFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_OFF;
         setup_ff <= '0;
         idle_ff  <= '0;
         svc_ff   <= '0;
         dep_ff   <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         setup_ff <= setup_in;
         idle_ff  <= idle_in;
         svc_ff   <= svc_in;
         dep_ff   <= dep_in;
      end
      tag_ff  <= tag_in;
      dtag_ff <= dtag_in;
   end

   assign mode      = mode_ff;
   assign idle_left = idle_ff;
   assign dep       = dep_ff;
   assign dep_tag   = dtag_ff;

endmodule
`default_nettype wire

// ===== hdl/sdd_queue_cell.sv =====
// One slot of the job queue; takes its right neighbor's entry on shift, a new job on load.
// Depends on sdd_pkg.
`default_nettype none
module sdd_queue_cell
   import sdd_pkg::*;
#(
   parameter int TIME_BITS = 16,
   parameter int OWN_W     = 3
) (
   input  wire logic                 clock,
   input  wire logic                 shift,
   input  wire logic                 load,
   input  wire logic [TAG_W-1:0]     nb_tag,
   input  wire logic [TIME_BITS-1:0] nb_svc,
   input  wire logic                 nb_mark,
   input  wire logic [OWN_W-1:0]     nb_own,
   input  wire logic [TAG_W-1:0]     new_tag,
   input  wire logic [TIME_BITS-1:0] new_svc,
   input  wire logic                 new_mark,
   input  wire logic [OWN_W-1:0]     new_own,
   output logic [TAG_W-1:0]          tag,
   output logic [TIME_BITS-1:0]      svc,
   output logic                      mark,
   output logic [OWN_W-1:0]          own
);

   logic [TAG_W-1:0]     tag_ff;
   logic [TIME_BITS-1:0] svc_ff;
   logic                 mark_ff;
   logic [OWN_W-1:0]     own_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         tag_ff  <= new_tag;
         svc_ff  <= new_svc;
         mark_ff <= new_mark;
         own_ff  <= new_own;
      end else if (shift) begin
         tag_ff  <= nb_tag;
         svc_ff  <= nb_svc;
         mark_ff <= nb_mark;
         own_ff  <= nb_own;
      end
   end

   assign tag  = tag_ff;
   assign svc  = svc_ff;
   assign mark = mark_ff;
   assign own  = own_ff;

endmodule
`default_nettype wire

// ===== hdl/setup_delayedoff_server_dispatcher.sv =====
// Top level of the setup/delayed-off server dispatcher: sequencer, CSRs, server and queue rows.
// Depends on sdd_pkg, sdd_server_cell and sdd_queue_cell.
`default_nettype none
// Each transfer on the request side is one time tick, optionally with a job arriving
// (req_func high). The block holds busy high while it works on a tick, and reports one
// result per finished job in server index order, or a single result with
// rsp_departure_valid low when no job finished; rsp_last marks the final result of the
// tick. Results appear for exactly one cycle on rsp_valid and cannot be held off.
// A tick runs the countdowns, scans the servers in use (clamped servers_in_use) for the
// best one and, when a job arrives, places it and scans them once more; it then dispatches,
// steps through the server indices up to the highest one that finished a job, or through
// index 0 alone when none did, and returns to idle before the next start. The server scan
// takes one server per cycle. Write the CSRs only while idle.
module setup_delayedoff_server_dispatcher
   import sdd_pkg::*;
#(
   parameter int NUM_SERVERS = 8,
   parameter int QUEUE_DEPTH = 64,
   parameter int TIME_BITS   = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                start,
   output logic                     busy,
   input  wire logic                req_func,
   input  wire logic [CFG_W-1:0]    req_service_ticks,
   input  wire logic [TAG_W-1:0]    req_arriving_tag,
   // result channel
   output logic                     rsp_valid,
   output logic                     rsp_departure_valid,
   output logic [TAG_W-1:0]         rsp_departed_tag,
   output logic [SIDX_W-1:0]        rsp_server_index,
   output logic                     rsp_arrival_dropped,
   output logic                     rsp_all_servers_off,
   output logic [QJOBS_W-1:0]       rsp_queued_jobs,
   output logic                     rsp_last,
   // configuration port
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [PADDR_W-1:0]  paddr,
   input  wire logic [PDATA_W-1:0]  pwdata,
   output logic [PDATA_W-1:0]       prdata,
   output logic                     pready
);

   localparam int IW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
   localparam int NW = $clog2(NUM_SERVERS + 1);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_TICK     = 7'b0000010,
      ST_SCAN1    = 7'b0000100,
      ST_ARRIVE   = 7'b0001000,
      ST_SCAN2    = 7'b0010000,
      ST_DISPATCH = 7'b0100000,
      ST_EMIT     = 7'b1000000
   } state_type;

   // ---------------------------------------------------------------- CSRs
   logic [CFG_W-1:0]   setup_cfg_ff, doff_cfg_ff;
   logic [INUSE_W-1:0] inuse_cfg_ff;
   reg_idx_type        reg_sel;
   logic               csr_wr;

   assign pready  = 1'b1;
   assign reg_sel = reg_idx_type'(paddr[3:2]);
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_cfg_ff <= CFG_W'(50);
         doff_cfg_ff  <= CFG_W'(100);
         inuse_cfg_ff <= INUSE_W'(8);
      end else if (csr_wr) begin
         unique case (reg_sel)
            REG_SETUP_TICKS: setup_cfg_ff <= pwdata[CFG_W-1:0];
            REG_DOFF_TICKS:  doff_cfg_ff  <= pwdata[CFG_W-1:0];
            REG_IN_USE:      inuse_cfg_ff <= pwdata[INUSE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_SETUP_TICKS: prdata = PDATA_W'(setup_cfg_ff);
         REG_DOFF_TICKS:  prdata = PDATA_W'(doff_cfg_ff);
         REG_IN_USE:      prdata = PDATA_W'(inuse_cfg_ff);
         default:         prdata = '0;
      endcase
   end

   // clamp servers in use to 1..NUM_SERVERS
   logic [NW-1:0] n_act;
   logic [IW-1:0] n_last;
   always_comb begin
      if (inuse_cfg_ff == '0)                     n_act = NW'(1);
      else if (32'(inuse_cfg_ff) > NUM_SERVERS)   n_act = NW'(NUM_SERVERS);
      else                                        n_act = NW'(inuse_cfg_ff);
   end
   assign n_last = IW'(n_act - 1'b1);

   // ---------------------------------------------------------------- sequencer regs
   state_type             state_ff, state_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic                  func_ff;
   logic [TIME_BITS-1:0]  svc_ff;
   logic [TAG_W-1:0]      tag_ff;
   logic [IW-1:0]         best_ff, best_in;
   logic [1:0]            brank_ff, brank_in;
   logic [TIME_BITS-1:0]  bidle_ff, bidle_in;
   logic                  drop_ff, drop_in;
   logic [CW-1:0]         count_ff, count_in;

   // ---------------------------------------------------------------- server row
   cell_cmd_type          cmd [NUM_SERVERS];
   mode_type              s_mode [NUM_SERVERS];
   logic [TIME_BITS-1:0]  s_idle [NUM_SERVERS];
   logic [NUM_SERVERS-1:0] s_dep;
   logic [TAG_W-1:0]      s_dtag [NUM_SERVERS];
   logic [TIME_BITS-1:0]  job_svc;
   logic [TAG_W-1:0]      job_tag;

   for (genvar g = 0; g < NUM_SERVERS; g++) begin : g_srv
      sdd_server_cell #(.TIME_BITS(TIME_BITS)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd[g]),
         .setup_ticks (TIME_BITS'(setup_cfg_ff)),
         .doff_ticks  (TIME_BITS'(doff_cfg_ff)),
         .job_svc     (job_svc),
         .job_tag     (job_tag),
         .mode        (s_mode[g]),
         .idle_left   (s_idle[g]),
         .dep         (s_dep[g]),
         .dep_tag     (s_dtag[g])
      );
   end

   // ---------------------------------------------------------------- queue row
   logic [TAG_W-1:0]       q_tag [QUEUE_DEPTH];
   logic [TIME_BITS-1:0]   q_svc [QUEUE_DEPTH];
   logic                   q_mark [QUEUE_DEPTH];
   logic [IW-1:0]          q_own [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] q_cand, q_pre, q_first, q_shift, q_load;
   logic                   new_mark;
   logic [IW-1:0]          new_own;

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_q
      logic [TAG_W-1:0]     nb_tag;
      logic [TIME_BITS-1:0] nb_svc;
      logic                 nb_mark;
      logic [IW-1:0]        nb_own;
      if (g == QUEUE_DEPTH - 1) begin : g_end
         assign nb_tag  = '0;
         assign nb_svc  = '0;
         assign nb_mark = 1'b0;
         assign nb_own  = '0;
      end else begin : g_mid
         assign nb_tag  = q_tag[g+1];
         assign nb_svc  = q_svc[g+1];
         assign nb_mark = q_mark[g+1];
         assign nb_own  = q_own[g+1];
      end
      // unmarked live entries, and the prefix marking everything from the first one on
      assign q_cand[g] = (CW'(g) < count_ff) && !q_mark[g];
      assign q_pre[g]  = |q_cand[g:0];
      if (g == 0) begin : g_f0
         assign q_first[g] = q_cand[g];
      end else begin : g_fn
         assign q_first[g] = q_cand[g] && !q_pre[g-1];
      end

      sdd_queue_cell #(.TIME_BITS(TIME_BITS), .OWN_W(IW)) u_slot (
         .clock    (clock),
         .shift    (q_shift[g]),
         .load     (q_load[g]),
         .nb_tag   (nb_tag),
         .nb_svc   (nb_svc),
         .nb_mark  (nb_mark),
         .nb_own   (nb_own),
         .new_tag  (tag_ff),
         .new_svc  (svc_ff),
         .new_mark (new_mark),
         .new_own  (new_own),
         .tag      (q_tag[g]),
         .svc      (q_svc[g]),
         .mark     (q_mark[g]),
         .own      (q_own[g])
      );
   end

   // pick the first unmarked entry
   logic [TAG_W-1:0]     fu_tag;
   logic [TIME_BITS-1:0] fu_svc;
   always_comb begin
      fu_tag = '0;
      fu_svc = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         fu_tag = fu_tag | (q_first[i] ? q_tag[i] : '0);
         fu_svc = fu_svc | (q_first[i] ? q_svc[i] : '0);
      end
   end

   // ---------------------------------------------------------------- scan and decisions
   logic [1:0]            cur_rank;
   logic                  take;
   logic                  full;
   logic                  take_head;
   logic                  dsp_go;
   logic                  last_idx;
   logic [NUM_SERVERS-1:0] dep_hi;
   logic                  all_off;

   assign cur_rank = rank_of(s_mode[idx_ff]);
   assign take     = (idx_ff == '0) || (cur_rank < brank_ff) ||
                     (cur_rank == RANK_DOFF && brank_ff == RANK_DOFF &&
                      s_idle[idx_ff] > bidle_ff);
   assign full      = (count_ff >= CW'(QUEUE_DEPTH));
   assign dsp_go    = (count_ff != '0) && (brank_ff == RANK_DOFF);
   assign take_head = !q_mark[0] || (q_own[0] == best_ff) || !q_pre[QUEUE_DEPTH-1];
   assign last_idx  = (idx_ff == IW'(NUM_SERVERS - 1));
   assign new_mark  = (brank_ff == RANK_OFF);
   assign new_own   = new_mark ? best_ff : '0;

   always_comb begin
      for (int i = 0; i < NUM_SERVERS; i++) begin
         dep_hi[i] = s_dep[i] && (i > 32'(idx_ff));
      end
      all_off = 1'b1;
      for (int i = 0; i < NUM_SERVERS; i++) begin
         if (i < 32'(n_act) && s_mode[i] != MODE_OFF) all_off = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      best_in  = best_ff;
      brank_in = brank_ff;
      bidle_in = bidle_ff;
      drop_in  = drop_ff;
      count_in = count_ff;
      job_svc  = svc_ff;
      job_tag  = tag_ff;
      q_shift  = '0;
      q_load   = '0;
      for (int i = 0; i < NUM_SERVERS; i++) cmd[i] = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_TICK;
         end
         ST_TICK: begin
            for (int i = 0; i < NUM_SERVERS; i++) cmd[i].tick = 1'b1;
            drop_in  = 1'b0;
            idx_in   = '0;
            state_in = func_ff ? ST_SCAN1 : ST_SCAN2;
         end
         ST_SCAN1, ST_SCAN2: begin
            if (take) begin
               best_in  = idx_ff;
               brank_in = cur_rank;
               bidle_in = s_idle[idx_ff];
            end
            if (idx_ff == n_last) begin
               idx_in   = '0;
               state_in = (state_ff == ST_SCAN1) ? ST_ARRIVE : ST_DISPATCH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_ARRIVE: begin
            // start on a delayed-off best, else drop if full, else queue; power up an off best
            if (brank_ff == RANK_DOFF) begin
               cmd[best_ff].start = 1'b1;
            end else if (full) begin
               drop_in = 1'b1;
            end else begin
               for (int i = 0; i < QUEUE_DEPTH; i++) q_load[i] = (CW'(i) == count_ff);
               count_in = count_ff + 1'b1;
               if (brank_ff == RANK_OFF) cmd[best_ff].power_up = 1'b1;
            end
            state_in = ST_SCAN2;
         end
         ST_DISPATCH: begin
            if (dsp_go) begin
               cmd[best_ff].start = 1'b1;
               if (take_head) begin
                  job_svc = q_svc[0];
                  job_tag = q_tag[0];
                  q_shift = '1;
               end else begin
                  job_svc = fu_svc;
                  job_tag = fu_tag;
                  q_shift = q_pre;
               end
               // only marked jobs left: the head's owner stops its setup
               if (!(!q_mark[0] || q_own[0] == best_ff) && !q_pre[QUEUE_DEPTH-1] &&
                   q_own[0] != best_ff) begin
                  cmd[q_own[0]].shut_off = 1'b1;
               end
               count_in = count_ff - 1'b1;
            end
            idx_in   = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            idx_in = idx_ff + 1'b1;
            if (s_dep == '0 || (s_dep[idx_ff] && dep_hi == '0) || last_idx) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- result register
   logic                  rsp_valid_ff;
   logic                  rsp_dv_ff;
   logic [TAG_W-1:0]      rsp_tag_ff;
   logic [SIDX_W-1:0]     rsp_idx_ff;
   logic                  rsp_drop_ff, rsp_off_ff, rsp_last_ff;
   logic [QJOBS_W-1:0]    rsp_qj_ff;
   logic                  emit_now;

   assign emit_now = (state_ff == ST_EMIT) && ((s_dep == '0) || s_dep[idx_ff]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= emit_now;
      end
      best_ff  <= best_in;
      brank_ff <= brank_in;
      bidle_ff <= bidle_in;
      if (state_ff == ST_IDLE && start) begin
         func_ff <= req_func;
         svc_ff  <= TIME_BITS'(req_service_ticks);
         tag_ff  <= req_arriving_tag;
      end
      if (emit_now) begin
         rsp_dv_ff   <= (s_dep != '0);
         rsp_tag_ff  <= (s_dep != '0) ? s_dtag[idx_ff] : '0;
         rsp_idx_ff  <= (s_dep != '0) ? SIDX_W'(idx_ff) : '0;
         rsp_drop_ff <= drop_ff;
         rsp_off_ff  <= all_off;
         rsp_qj_ff   <= QJOBS_W'(count_ff);
         rsp_last_ff <= (s_dep == '0) || (dep_hi == '0);
      end
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_departure_valid = rsp_dv_ff;
   assign rsp_departed_tag    = rsp_tag_ff;
   assign rsp_server_index    = rsp_idx_ff;
   assign rsp_arrival_dropped = rsp_drop_ff;
   assign rsp_all_servers_off = rsp_off_ff;
   assign rsp_queued_jobs     = rsp_qj_ff;
   assign rsp_last            = rsp_last_ff;

   // ---------------------------------------------------------------- assertions
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_EMIT))
      else $error("result without emit phase");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result right after a transfer in");

endmodule
`default_nettype wire
